// ===== rtl/core/osu_pkg.sv =====
package osu_pkg;

  // Receive FIFO geometry.
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Field widths.
  localparam int BYTE_W    = 8;
  localparam int FRAME_W   = 10;
  localparam int CNT_W     = 4;
  localparam int TX_TICK_W = 2;
  localparam int RX_TICK_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  // Bit timing in ticks.
  localparam logic [TX_TICK_W-1:0] TX_BIT_TICKS   = 2'd3;
  localparam logic [RX_TICK_W-1:0] RX_FIRST_TICKS = 3'd4;
  localparam logic [RX_TICK_W-1:0] RX_BIT_TICKS   = 3'd3;

  // Bytes with special handling.
  localparam logic [BYTE_W-1:0] BYTE_DROP    = 8'hC2;
  localparam logic [BYTE_W-1:0] BYTE_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SEND  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_FLUSH = 2'd3
  } osu_req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BUSY  = 2'd1,
    STAT_EMPTY = 2'd2
  } osu_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_ENABLE       = 2'd0,
    CFG_RX_SAMPLE_COUNT = 2'd1,
    CFG_TX_BIT_COUNT    = 2'd2
  } osu_cfg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } osu_state_t;

  // Byte offered by the receiver at the end of a stop bit.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } osu_push_t;

  // Transmitter status seen by the control logic.
  typedef struct packed {
    logic active;
    logic level;
  } osu_tx_stat_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/osu_req_if.sv =====
interface osu_req_if;
  import osu_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic              rx_line;
  logic [BYTE_W-1:0] send_byte;

  modport source (output valid, req_type, rx_line, send_byte, input ready);
  modport sink   (input valid, req_type, rx_line, send_byte, output ready);
endinterface

// ===== rtl/core/osu_rsp_if.sv =====
interface osu_rsp_if;
  import osu_pkg::*;
  logic              valid;
  logic              ready;
  logic              tx_line;
  logic [1:0]        status;
  logic [BYTE_W-1:0] read_data;
  logic              tx_busy;
  logic              rx_nonempty;

  modport source (output valid, tx_line, status, read_data, tx_busy, rx_nonempty,
                  input ready);
  modport sink   (input valid, tx_line, status, read_data, tx_busy, rx_nonempty,
                  output ready);
endinterface

// ===== rtl/core/osu_cfg_if.sv =====
interface osu_cfg_if;
  import osu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/oversampled_soft_uart_unit.sv =====
// Tick, send, flush and empty reads give their result in the cycle after the transfer.
// A read that pops entries gives its result after the last popped entry, one RAM read
// per popped entry. Other items go at one per cycle while the result sink keeps up.
// Reset is synchronous and active high: control state and pointers clear, the line idles
// high, configuration returns to enabled receiver and ten bits; FIFO RAM is not cleared.
module oversampled_soft_uart_unit
  import osu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  osu_req_if.sink   req,
  osu_rsp_if.source rsp,
  osu_cfg_if.sink   cfg
);

  osu_state_t        state, state_next;
  logic [PTR_W-1:0]  wptr, wptr_next;
  logic [PTR_W-1:0]  rptr, rptr_next;
  logic              out_valid, out_valid_next;
  osu_status_t       out_status, out_status_next;
  logic [BYTE_W-1:0] out_data, out_data_next;

  logic             rx_enable;
  logic [CNT_W-1:0] rx_sample_count;
  logic [CNT_W-1:0] tx_bit_count;

  logic              in_xfer, tick, send_go;
  osu_tx_stat_t      tx_stat;
  osu_push_t         push;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [PTR_W-1:0]  rptr_inc;

  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable       <= 1'b1;
      rx_sample_count <= CNT_W'(10);
      tx_bit_count    <= CNT_W'(10);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RX_ENABLE:       rx_enable       <= cfg.data[0];
        CFG_RX_SAMPLE_COUNT: rx_sample_count <= cfg.data;
        CFG_TX_BIT_COUNT:    tx_bit_count    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Input transfer decode.
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign in_xfer   = req.valid && req.ready;
  assign tick      = in_xfer && (req.req_type == REQ_TICK);
  assign send_go   = in_xfer && (req.req_type == REQ_SEND) && !tx_stat.active;

  osu_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .load      (send_go),
    .load_byte (req.send_byte),
    .bit_count (tx_bit_count),
    .stat      (tx_stat)
  );

  osu_rx u_rx (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .line         (req.rx_line),
    .enable       (rx_enable),
    .sample_count (rx_sample_count),
    .push         (push)
  );

  osu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr),
    .wdata (push.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rptr_inc = ptr_inc(rptr);

  // Request handling and the read loop that skips newlines and dropped bytes.
  always_comb begin
    state_next      = state;
    wptr_next       = wptr;
    rptr_next       = rptr;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_data_next   = out_data;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = rptr;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          out_status_next = STAT_OK;
          out_data_next   = '0;
          case (req.req_type)
            REQ_TICK: begin
              out_valid_next = 1'b1;
              if (push.valid && (ptr_inc(wptr) != rptr)) begin
                ram_we    = 1'b1;
                wptr_next = ptr_inc(wptr);
              end
            end
            REQ_SEND: begin
              out_valid_next = 1'b1;
              if (tx_stat.active) begin
                out_status_next = STAT_BUSY;
              end
            end
            REQ_READ: begin
              if (rptr == wptr) begin
                out_valid_next  = 1'b1;
                out_status_next = STAT_EMPTY;
              end else begin
                ram_re     = 1'b1;
                state_next = ST_READ;
              end
            end
            REQ_FLUSH: begin
              out_valid_next = 1'b1;
              wptr_next      = '0;
              rptr_next      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        rptr_next = rptr_inc;
        if ((ram_rdata == BYTE_NEWLINE) || (ram_rdata == BYTE_DROP)) begin
          if (rptr_inc == wptr) begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_EMPTY;
            out_data_next   = '0;
            state_next      = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rptr_inc;
          end
        end else begin
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_data_next   = ram_rdata;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wptr      <= '0;
      rptr      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wptr      <= wptr_next;
      rptr      <= rptr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_data   <= out_data_next;
  end

  // Transmitter and FIFO levels only move when a new item is taken or a read steps through the FIFO.
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_data   = out_data;
  assign rsp.tx_line     = tx_stat.level;
  assign rsp.tx_busy     = tx_stat.active;
  assign rsp.rx_nonempty = (wptr != rptr);

endmodule

// ===== rtl/core/osu_ram.sv =====
module osu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/osu_tx.sv =====
module osu_tx
  import osu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              load,
  input  logic [BYTE_W-1:0] load_byte,
  input  logic [CNT_W-1:0]  bit_count,
  output osu_tx_stat_t      stat
);

  logic                 active, active_next;
  logic                 level, level_next;
  logic [TX_TICK_W-1:0] tick_count, tick_count_next;
  logic [FRAME_W-1:0]   shift, shift_next;
  logic [CNT_W-1:0]     bits_left, bits_left_next;

  // Frame load on a send and bit shifting on ticks.
  always_comb begin
    active_next     = active;
    level_next      = level;
    tick_count_next = tick_count;
    shift_next      = shift;
    bits_left_next  = bits_left;
    if (load) begin
      shift_next      = {1'b1, load_byte, 1'b0};
      bits_left_next  = bit_count;
      tick_count_next = TX_BIT_TICKS;
      active_next     = 1'b1;
    end else if (tick && active) begin
      if (tick_count > TX_TICK_W'(1)) begin
        tick_count_next = tick_count - TX_TICK_W'(1);
      end else begin
        level_next      = shift[0];
        shift_next      = {1'b0, shift[FRAME_W-1:1]};
        tick_count_next = TX_BIT_TICKS;
        if (bits_left <= CNT_W'(1)) begin
          bits_left_next = '0;
          active_next    = 1'b0;
          level_next     = 1'b1;
        end else begin
          bits_left_next = bits_left - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      level      <= 1'b1;
      tick_count <= '0;
      shift      <= '0;
      bits_left  <= '0;
    end else begin
      active     <= active_next;
      level      <= level_next;
      tick_count <= tick_count_next;
      shift      <= shift_next;
      bits_left  <= bits_left_next;
    end
  end

  assign stat.active = active;
  assign stat.level  = level;

endmodule

// ===== rtl/core/osu_rx.sv =====
module osu_rx
  import osu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             line,
  input  logic             enable,
  input  logic [CNT_W-1:0] sample_count,
  output osu_push_t        push
);

  logic                 in_frame, in_frame_next;
  logic                 await_stop, await_stop_next;
  logic [RX_TICK_W-1:0] tick_count, tick_count_next;
  logic [CNT_W-1:0]     bits_left, bits_left_next;
  logic [CNT_W-1:0]     bit_pos, bit_pos_next;
  logic [BYTE_W-1:0]    assembled, assembled_next;

  // Start detection, bit sampling and the stop bit wait.
  always_comb begin
    in_frame_next   = in_frame;
    await_stop_next = await_stop;
    tick_count_next = tick_count;
    bits_left_next  = bits_left;
    bit_pos_next    = bit_pos;
    assembled_next  = assembled;
    push.valid      = 1'b0;
    push.data       = assembled;
    if (tick && enable) begin
      if (await_stop) begin
        if (tick_count > RX_TICK_W'(1)) begin
          tick_count_next = tick_count - RX_TICK_W'(1);
        end else begin
          tick_count_next = '0;
          await_stop_next = 1'b0;
          in_frame_next   = 1'b0;
          push.valid      = (assembled != BYTE_DROP);
        end
      end else if (!in_frame) begin
        if (!line) begin
          in_frame_next   = 1'b1;
          assembled_next  = '0;
          tick_count_next = RX_FIRST_TICKS;
          bits_left_next  = sample_count;
          bit_pos_next    = '0;
        end
      end else if (tick_count > RX_TICK_W'(1)) begin
        tick_count_next = tick_count - RX_TICK_W'(1);
      end else begin
        tick_count_next = RX_BIT_TICKS;
        if (line && !bit_pos[CNT_W-1]) begin
          assembled_next[bit_pos[2:0]] = 1'b1;
        end
        bit_pos_next = bit_pos + CNT_W'(1);
        if (bits_left <= CNT_W'(1)) begin
          bits_left_next  = '0;
          await_stop_next = 1'b1;
        end else begin
          bits_left_next = bits_left - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      await_stop <= 1'b0;
      tick_count <= '0;
      bits_left  <= '0;
      bit_pos    <= '0;
      assembled  <= '0;
    end else begin
      in_frame   <= in_frame_next;
      await_stop <= await_stop_next;
      tick_count <= tick_count_next;
      bits_left  <= bits_left_next;
      bit_pos    <= bit_pos_next;
      assembled  <= assembled_next;
    end
  end

endmodule

// ===== tb/osu_reply_checker.sv =====
// Watches the request, response and configuration channels of the soft UART, predicts
// every response from its own copy of the transmitter, receiver and receive FIFO, and
// compares each response transfer against the oldest prediction.
module osu_reply_checker
  import osu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  osu_req_if   req,
  osu_rsp_if   rsp,
  osu_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              tx_line;
    osu_status_t       status;
    logic [BYTE_W-1:0] read_data;
    logic              tx_busy;
    logic              rx_nonempty;
  } uart_reply_t;

  // Configuration copy.
  logic             cfg_rx_en;
  logic [CNT_W-1:0] cfg_samples;
  logic [CNT_W-1:0] cfg_tx_bits;

  // Transmitter copy.
  logic                 tx_on;
  logic [TX_TICK_W-1:0] tx_wait;
  logic [FRAME_W-1:0]   tx_frame;
  logic [CNT_W-1:0]     tx_left;
  logic                 tx_out;

  // Receiver copy.
  logic                 rx_busy;
  logic                 rx_stop_wait;
  logic [RX_TICK_W-1:0] rx_wait;
  logic [CNT_W-1:0]     rx_left;
  logic [CNT_W-1:0]     rx_pos;
  logic [BYTE_W-1:0]    rx_byte;

  // Receive ring copy.
  logic [BYTE_W-1:0] ring_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  uart_reply_t awaited_replies[$];

  task automatic clear_uart();
    cfg_rx_en    = 1'b1;
    cfg_samples  = CNT_W'(10);
    cfg_tx_bits  = CNT_W'(10);
    tx_on        = 1'b0;
    tx_wait      = '0;
    tx_frame     = '0;
    tx_left      = '0;
    tx_out       = 1'b1;
    rx_busy      = 1'b0;
    rx_stop_wait = 1'b0;
    rx_wait      = '0;
    rx_left      = '0;
    rx_pos       = '0;
    rx_byte      = '0;
    wr_ptr       = '0;
    rd_ptr       = '0;
  endtask

  function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % FIFO_DEPTH);
  endfunction

  // One slot stays free, so a byte arriving at a full ring is lost.
  task automatic ring_store(logic [BYTE_W-1:0] b);
    if (ring_step(wr_ptr) != rd_ptr) begin
      ring_mem[wr_ptr] = b;
      wr_ptr = ring_step(wr_ptr);
    end
  endtask

  // Each bit is held for three ticks; the line goes back high with the last counted bit.
  task automatic tx_advance();
    if (!tx_on) return;
    if (tx_wait > 1) begin
      tx_wait--;
      return;
    end
    tx_out   = tx_frame[0];
    tx_frame = tx_frame >> 1;
    tx_wait  = TX_BIT_TICKS;
    if (tx_left <= 1) begin
      tx_left = '0;
      tx_on   = 1'b0;
      tx_out  = 1'b1;
    end else begin
      tx_left--;
    end
  endtask

  // Start found on a low level, first sample four ticks later, then one every three.
  task automatic rx_advance(logic line);
    if (!cfg_rx_en) return;
    if (rx_stop_wait) begin
      if (rx_wait > 1) begin
        rx_wait--;
        return;
      end
      rx_wait      = '0;
      rx_stop_wait = 1'b0;
      rx_busy      = 1'b0;
      if (rx_byte != BYTE_DROP) ring_store(rx_byte);
      return;
    end
    if (!rx_busy) begin
      if (!line) begin
        rx_busy = 1'b1;
        rx_byte = '0;
        rx_wait = RX_FIRST_TICKS;
        rx_left = cfg_samples;
        rx_pos  = '0;
      end
      return;
    end
    if (rx_wait > 1) begin
      rx_wait--;
      return;
    end
    rx_wait = RX_BIT_TICKS;
    // Samples past the eighth are taken but not kept.
    if (line && rx_pos < 8) rx_byte[rx_pos[2:0]] = 1'b1;
    rx_pos++;
    if (rx_left <= 1) begin
      rx_left      = '0;
      rx_stop_wait = 1'b1;
    end else begin
      rx_left--;
    end
  endtask

  task automatic uart_reply(input osu_req_t kind, input logic line,
                            input logic [BYTE_W-1:0] data, output uart_reply_t r);
    logic [BYTE_W-1:0] popped;
    r.status    = STAT_OK;
    r.read_data = '0;
    case (kind)
      REQ_TICK: begin
        tx_advance();
        rx_advance(line);
      end
      REQ_SEND: begin
        if (tx_on) begin
          r.status = STAT_BUSY;
        end else begin
          tx_frame = {1'b1, data, 1'b0};
          tx_left  = cfg_tx_bits;
          tx_wait  = TX_BIT_TICKS;
          tx_on    = 1'b1;
        end
      end
      REQ_READ: begin
        // Newlines and dropped bytes are consumed without being returned.
        r.status = STAT_EMPTY;
        while (rd_ptr != wr_ptr && r.status == STAT_EMPTY) begin
          popped = ring_mem[rd_ptr];
          rd_ptr = ring_step(rd_ptr);
          if (popped != BYTE_NEWLINE && popped != BYTE_DROP) begin
            r.status    = STAT_OK;
            r.read_data = popped;
          end
        end
      end
      default: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
    endcase
    r.tx_line     = tx_out;
    r.tx_busy     = tx_on;
    r.rx_nonempty = (wr_ptr != rd_ptr);
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_reply();
    uart_reply_t want;
    if (awaited_replies.size() == 0) begin
      $error("response transfer with no prediction waiting");
      mismatches++;
      return;
    end
    want = awaited_replies.pop_front();
    check_field("tx_line", BYTE_W'(want.tx_line), BYTE_W'(rsp.tx_line));
    check_field("status", BYTE_W'(want.status), BYTE_W'(rsp.status));
    check_field("read_data", want.read_data, rsp.read_data);
    check_field("tx_busy", BYTE_W'(want.tx_busy), BYTE_W'(rsp.tx_busy));
    check_field("rx_nonempty", BYTE_W'(want.rx_nonempty), BYTE_W'(rsp.rx_nonempty));
  endtask

  // Responses are compared before the new request is predicted, since a response
  // can never belong to a request taken at the same edge.
  always @(posedge clk) begin
    uart_reply_t fresh;
    if (rst) begin
      clear_uart();
      awaited_replies.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (osu_cfg_idx_t'(cfg.index))
          CFG_RX_ENABLE:       cfg_rx_en   = cfg.data[0];
          CFG_RX_SAMPLE_COUNT: cfg_samples = cfg.data;
          CFG_TX_BIT_COUNT:    cfg_tx_bits = cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) check_reply();
      if (req.valid && req.ready) begin
        uart_reply(osu_req_t'(req.req_type), req.rx_line, req.send_byte, fresh);
        awaited_replies.push_back(fresh);
      end
    end
    outstanding <= awaited_replies.size();
  end

endmodule

// ===== tb/tb_oversampled_soft_uart_unit.sv =====
module tb_oversampled_soft_uart_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import osu_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam osu_cfg_idx_t CFG_SPARE = osu_cfg_idx_t'(2'd3);

  logic clk;
  logic rst;

  osu_req_if req_ch ();
  osu_rsp_if rsp_ch ();
  osu_cfg_if cfg_ch ();

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int take_idle_pct;
  int hold_asked;
  int items_sent;
  int quiet_cycles;

  oversampled_soft_uart_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  osu_reply_checker reply_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The clock starts low so that no rising edge falls at time zero.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Response sink: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_asked) begin
        holds_served = hold_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** oversampled_soft_uart_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid stays high from one transfer to the next unless the sender idles.
  task automatic offer(osu_req_t kind, logic line, logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.rx_line   <= line;
    req_ch.send_byte <= data;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic write_reg(osu_cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Stop offering and wait until every predicted response has come back.
  task automatic settle(int linger);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (linger) @(posedge clk);
  endtask

  task automatic configure(logic en, logic [CNT_W-1:0] samples, logic [CNT_W-1:0] bits,
                           bit probe_spare);
    settle(4);
    // An unassigned index must leave every register alone.
    if (probe_spare) write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
    write_reg(CFG_RX_ENABLE, {3'($urandom), en});
    write_reg(CFG_RX_SAMPLE_COUNT, samples);
    write_reg(CFG_TX_BIT_COUNT, bits);
    cfg_ch.valid <= 1'b0;
  endtask

  // Received bytes lean toward newlines, the dropped code and the extremes.
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return BYTE_NEWLINE;
    if (roll < 30) return BYTE_DROP;
    if (roll < 34) return 8'h00;
    if (roll < 38) return 8'hFF;
    return BYTE_W'($urandom);
  endfunction

  // Sends, reads, read bursts and flushes scattered between ticks.
  task automatic side_traffic(int read_pct);
    int unsigned roll;
    roll = $urandom_range(999);
    if (roll < 80) begin
      offer(REQ_SEND, 1'($urandom), pick_byte());
    end else if (read_pct > 0) begin
      if (roll < 80 + 10 * read_pct) begin
        offer(REQ_READ, 1'($urandom), BYTE_W'($urandom));
      end else if (roll < 90 + 10 * read_pct) begin
        repeat ($urandom_range(1, FIFO_DEPTH + 1))
          offer(REQ_READ, 1'($urandom), BYTE_W'($urandom));
      end else if (roll < 96 + 10 * read_pct) begin
        offer(REQ_FLUSH, 1'($urandom), BYTE_W'($urandom));
      end
    end
  endtask

  // One frame on the receive line, three ticks per bit, long enough for the
  // receiver to finish; now and then pure noise or a glitched tick.
  task automatic receive_frame(logic [CNT_W-1:0] samples, int read_pct);
    logic [FRAME_W-1:0] wave;
    int                 span;
    bit                 broken;
    logic               line;
    wave   = {1'b1, pick_byte(), 1'b0};
    span   = 3 * ((samples == 0) ? 1 : int'(samples)) + 8 + $urandom_range(3);
    broken = ($urandom_range(9) == 0);
    for (int t = 0; t < span; t++) begin
      if (broken) line = 1'($urandom);
      else line = (t < 3 * FRAME_W) ? wave[t / 3] : 1'b1;
      if ($urandom_range(49) == 0) line = ~line;
      offer(REQ_TICK, line, BYTE_W'($urandom));
      side_traffic(read_pct);
    end
  endtask

  initial begin
    // Per setting: receiver enable, sample count, transmit bits, read rate, item budget.
    logic             en_set   [6] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    logic [CNT_W-1:0] samp_set [6] = '{4'd10, 4'd1, 4'd15, 4'd8, 4'd0, 4'd9};
    logic [CNT_W-1:0] bits_set [6] = '{4'd10, 4'd1, 4'd15, 4'd0, 4'd12, 4'd10};
    int               read_set [6] = '{6, 0, 6, 6, 0, 6};
    int               budget   [6] = '{150, 260, 130, 100, 160, 150};
    int               goal;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_TICK;
    req_ch.rx_line   <= 1'b1;
    req_ch.send_byte <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_RX_ENABLE;
    cfg_ch.data      <= '0;
    send_idle_pct = 33;
    take_idle_pct = 60;
    hold_asked    = 0;
    items_sent    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the reset configuration.
    offer(REQ_READ, 1'b0, 8'h00);
    offer(REQ_FLUSH, 1'b1, 8'hFF);
    offer(REQ_TICK, 1'b1, 8'h00);
    offer(REQ_SEND, 1'b0, 8'h00);
    offer(REQ_SEND, 1'b1, 8'hFF);
    offer(REQ_TICK, 1'b0, 8'hFF);
    offer(REQ_TICK, 1'b0, 8'h00);
    offer(REQ_TICK, 1'b0, 8'h00);
    repeat (6) offer(REQ_TICK, 1'b1, 8'h55);
    offer(REQ_SEND, 1'b0, 8'hAA);
    offer(REQ_READ, 1'b1, 8'hFF);
    repeat (3) offer(REQ_TICK, 1'b0, 8'hAA);
    offer(REQ_FLUSH, 1'b0, 8'h00);
    offer(REQ_READ, 1'b0, 8'h00);

    // Random frames, two settings per idling pattern.
    goal = items_sent;
    for (int s = 0; s < 6; s++) begin
      configure(en_set[s], samp_set[s], bits_set[s], s == 0);
      case (s / 2)
        0: begin
          send_idle_pct = 33;
          take_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          take_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      // Long response hold-off while requests keep coming, to back up the block.
      if (s == 0 || s == 4) hold_asked++;
      goal += budget[s];
      while (items_sent < goal) receive_frame(samp_set[s], read_set[s]);
    end

    settle(20);
    if (mismatches == 0) begin
      $display("** oversampled_soft_uart_unit: PASSED **");
    end else begin
      $display("** oversampled_soft_uart_unit: FAILED **");
    end
    $finish;
  end

endmodule
